// ===== hdl/utf8_to_utf16_transcoder_defines.svh =====
// Assertion macros for the checker file.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define UTU_CHECK(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UTU_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/utu_pkg.sv =====
package utu_pkg;

  localparam int NumUnits = 4;
  localparam int CountWidth = $clog2(NumUnits + 1);
  localparam int IndexWidth = $clog2(NumUnits);

  localparam logic [15:0] ReplUnit = 16'hFFFD;
  localparam logic [20:0] MaxPoint = 21'h10FFFF;
  localparam logic [20:0] PlaneBase = 21'h010000;
  localparam logic [20:0] BmpMax = 21'h00FFFF;
  localparam logic [20:0] SurrFirst = 21'h00D800;
  localparam logic [20:0] SurrLast = 21'h00DFFF;
  localparam logic [15:0] HighSurr = 16'hD800;
  localparam logic [15:0] LowSurr = 16'hDC00;
  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag = 8'h80;

  typedef struct packed {
    logic [20:0] gathered;
    logic [1:0]  needed;
    logic [1:0]  taken;
  } seq_t;

  typedef struct packed {
    logic [NumUnits-1:0][15:0] units;
    logic [CountWidth-1:0]     count;
    logic                      last;
  } bundle_t;

endpackage

// ===== hdl/utu_decode.sv =====
module utu_decode (
  input  utu_pkg::seq_t    seq,
  input  logic [7:0]       text_byte,
  input  logic             text_last,
  output utu_pkg::seq_t    seq_next,
  output utu_pkg::bundle_t bundle
);

  always_comb begin
    logic [20:0] g_new;
    logic [20:0] v;
    logic [1:0]  need1;
    logic [1:0]  taken1;
    logic [utu_pkg::CountWidth-1:0] reps;
    logic [1:0]  tails;
    logic [15:0] t0;
    logic [15:0] t1;
    logic        is_cont;
    logic        lead_path;

    seq_next  = '0;
    reps      = '0;
    tails     = '0;
    t0        = utu_pkg::ReplUnit;
    t1        = utu_pkg::ReplUnit;
    lead_path = 1'b0;
    is_cont   = (text_byte & utu_pkg::ContMask) == utu_pkg::ContTag;
    g_new     = {seq.gathered[14:0], text_byte[5:0]};
    v         = g_new - utu_pkg::PlaneBase;
    need1     = seq.needed - 2'd1;
    taken1    = seq.taken + 2'd1;

    if (seq.needed != 2'd0) begin
      if (is_cont) begin
        if (need1 == 2'd0) begin
          tails = 2'd1;
          if (g_new <= utu_pkg::BmpMax) begin
            if (g_new inside {[utu_pkg::SurrFirst:utu_pkg::SurrLast]}) begin
              t0 = utu_pkg::ReplUnit;
            end else begin
              t0 = g_new[15:0];
            end
          end else if (g_new <= utu_pkg::MaxPoint) begin
            tails = 2'd2;
            t0    = utu_pkg::HighSurr | {6'd0, v[19:10]};
            t1    = utu_pkg::LowSurr | {6'd0, v[9:0]};
          end else begin
            t0 = utu_pkg::ReplUnit;
          end
        end else if (text_last) begin
          reps = utu_pkg::CountWidth'(1) + utu_pkg::CountWidth'(taken1);
        end else begin
          seq_next.gathered = g_new;
          seq_next.needed   = need1;
          seq_next.taken    = taken1;
        end
      end else begin
        reps      = utu_pkg::CountWidth'(1) + utu_pkg::CountWidth'(seq.taken);
        lead_path = 1'b1;
      end
    end else begin
      lead_path = 1'b1;
    end

    if (lead_path) begin
      if (text_byte inside {[8'h00:8'h7F]}) begin
        tails = 2'd1;
        t0    = {8'h00, text_byte};
      end else if (text_byte inside {[8'hC0:8'hDF]}) begin
        if (text_last) begin
          reps = reps + utu_pkg::CountWidth'(1);
        end else begin
          seq_next.gathered = {16'd0, text_byte[4:0]};
          seq_next.needed   = 2'd1;
        end
      end else if (text_byte inside {[8'hE0:8'hEF]}) begin
        if (text_last) begin
          reps = reps + utu_pkg::CountWidth'(1);
        end else begin
          seq_next.gathered = {17'd0, text_byte[3:0]};
          seq_next.needed   = 2'd2;
        end
      end else if (text_byte inside {[8'hF0:8'hF7]}) begin
        if (text_last) begin
          reps = reps + utu_pkg::CountWidth'(1);
        end else begin
          seq_next.gathered = {18'd0, text_byte[2:0]};
          seq_next.needed   = 2'd3;
        end
      end else begin
        reps = reps + utu_pkg::CountWidth'(1);
      end
    end

    bundle.count = reps + utu_pkg::CountWidth'(tails);
    bundle.last  = text_last;
    for (int i = 0; i < utu_pkg::NumUnits; i++) begin
      if (utu_pkg::CountWidth'(i) == reps) begin
        bundle.units[i] = t0;
      end else if (utu_pkg::CountWidth'(i) == reps + utu_pkg::CountWidth'(1)) begin
        bundle.units[i] = t1;
      end else begin
        bundle.units[i] = utu_pkg::ReplUnit;
      end
    end
  end

endmodule

// ===== hdl/utu_serializer.sv =====
module utu_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  utu_pkg::bundle_t bundle,
  output logic             free,
  output logic             unit_valid,
  input  logic             unit_stall,
  output logic [15:0]      code_unit,
  output logic             run_last,
  output logic             text_end
);

  logic                             busy;
  logic [utu_pkg::IndexWidth-1:0]   idx;
  utu_pkg::bundle_t                 held;
  logic                             final_unit;

  assign final_unit = utu_pkg::CountWidth'(idx) == held.count - utu_pkg::CountWidth'(1);
  assign free       = !busy || (!unit_stall && final_unit);
  assign unit_valid = busy;
  assign code_unit  = held.units[idx];
  assign run_last   = final_unit;
  assign text_end   = final_unit && held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && !unit_stall) begin
      if (final_unit) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + utu_pkg::IndexWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

endmodule

// ===== hdl/utf8_to_utf16_transcoder.sv =====
// Channel  Handshake                Payload
// text     text_valid / text_stall  text_byte[7:0], text_last
// unit     unit_valid / unit_stall  code_unit[15:0], run_last, text_end
//
// A byte is registered on entry and decoded in the next cycle into zero to four words.
// One byte per cycle is taken while each byte yields at most one word and unit_stall is low;
// a byte that yields more words holds the input until the serializer's bundle register sends its last word.
// Synchronous reset clears the pending sequence and empties both registers.
// A stalled output holds its word and backs up into text_stall without losing bytes.
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        text_last,
  output logic        unit_valid,
  input  logic        unit_stall,
  output logic [15:0] code_unit,
  output logic        run_last,
  output logic        text_end
);

  logic             in_vld;
  logic [7:0]       in_byte;
  logic             in_last;
  utu_pkg::seq_t    seq;
  utu_pkg::seq_t    seq_next;
  utu_pkg::bundle_t bundle;
  logic             free;
  logic             consume;
  logic             load;

  assign text_stall = in_vld && !free;
  assign consume    = in_vld && free;
  assign load       = consume && (bundle.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!text_stall) begin
      in_vld <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!text_stall && text_valid) begin
      in_byte <= text_byte;
      in_last <= text_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
    end else if (consume) begin
      seq <= seq_next;
    end
  end

  utu_decode u_decode (
    .seq       (seq),
    .text_byte (in_byte),
    .text_last (in_last),
    .seq_next  (seq_next),
    .bundle    (bundle)
  );

  utu_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .bundle     (bundle),
    .free       (free),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .code_unit  (code_unit),
    .run_last   (run_last),
    .text_end   (text_end)
  );

endmodule

// ===== hdl/utu_checker.sv =====
`include "utf8_to_utf16_transcoder_defines.svh"

module utu_checker (
  input logic        clk,
  input logic        rst,
  input logic        unit_valid,
  input logic        unit_stall,
  input logic [15:0] code_unit,
  input logic        run_last,
  input logic        text_end
);

  logic stalled;
  logic high_word;
  logic low_word;
  logic high_taken;

  assign stalled    = unit_valid && unit_stall;
  assign high_word  = code_unit[15:10] == 6'b110110;
  assign low_word   = code_unit[15:10] == 6'b110111;
  assign high_taken = unit_valid && !unit_stall && high_word;

  `UTU_CHECK_NEXT(a_stall_hold, stalled, unit_valid && $stable(code_unit), "stalled word changed")
  `UTU_CHECK(a_end_is_run_end, unit_valid && text_end, run_last, "text end without run end")
  `UTU_CHECK(a_high_not_last, unit_valid && high_word, !run_last, "high surrogate ends a run")
  `UTU_CHECK_NEXT(a_low_follows, high_taken, unit_valid && low_word, "low surrogate missing")

endmodule

bind utf8_to_utf16_transcoder utu_checker u_utu_checker (
  .clk        (clk),
  .rst        (rst),
  .unit_valid (unit_valid),
  .unit_stall (unit_stall),
  .code_unit  (code_unit),
  .run_last   (run_last),
  .text_end   (text_end)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallPct = 27;
  localparam int HoldStart = 60;
  localparam int HoldCycles = 40;
  localparam int QuietFirst = 150;
  localparam int QuietLast = 300;
  localparam int RandomBytes = 132;
  localparam int DrainCycles = 8;
  localparam int IdleLimit = 1000;

  typedef struct {
    logic [7:0] value;
    logic       ends_text;
  } text_item_t;

  typedef struct {
    logic [15:0] code;
    logic        run_end;
    logic        text_done;
  } unit_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_stall;
  logic [7:0]  text_byte = 8'h00;
  logic        text_last = 1'b0;
  logic        unit_valid;
  logic        unit_stall = 1'b0;
  logic [15:0] code_unit;
  logic        run_last;
  logic        text_end;

  text_item_t     pending_bytes[$];
  text_item_t     next_item;
  unit_word_t     expected_units[$];
  unit_word_t     want;
  logic [15:0]    fresh_units[$];
  utu_pkg::seq_t  utf8_seq = '0;

  logic        byte_accepted = 1'b0;
  int          cyc = 0;
  int          idle_cycles = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          mismatches = 0;
  int          end_rate = 0;
  logic        quiet;

  assign quiet = (cyc >= QuietFirst) && (cyc < QuietLast);

  utf8_to_utf16_transcoder dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_byte  (text_byte),
    .text_last  (text_last),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .code_unit  (code_unit),
    .run_last   (run_last),
    .text_end   (text_end)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void clear_seq();
    utf8_seq = '0;
  endfunction

  function automatic void fail_seq();
    fresh_units.push_back(utu_pkg::ReplUnit);
    for (int k = 0; k < utf8_seq.taken; k++) begin
      fresh_units.push_back(utu_pkg::ReplUnit);
    end
    clear_seq();
  endfunction

  function automatic void open_lead(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      fresh_units.push_back({8'h00, b});
    end else if (b[7:5] == 3'b110) begin
      utf8_seq.gathered = {16'h0000, b[4:0]};
      utf8_seq.needed = 2'd1;
      utf8_seq.taken = 2'd0;
    end else if (b[7:4] == 4'b1110) begin
      utf8_seq.gathered = {17'h00000, b[3:0]};
      utf8_seq.needed = 2'd2;
      utf8_seq.taken = 2'd0;
    end else if (b[7:3] == 5'b11110) begin
      utf8_seq.gathered = {18'h00000, b[2:0]};
      utf8_seq.needed = 2'd3;
      utf8_seq.taken = 2'd0;
    end else begin
      fresh_units.push_back(utu_pkg::ReplUnit);
    end
  endfunction

  function automatic void predict_utf16(input logic [7:0] b, input logic ends_text);
    logic [20:0] cp;
    logic [20:0] offset;
    unit_word_t  w;
    fresh_units.delete();
    if (utf8_seq.needed != 2'd0) begin
      if ((b & utu_pkg::ContMask) == utu_pkg::ContTag) begin
        utf8_seq.gathered = {utf8_seq.gathered[14:0], b[5:0]};
        utf8_seq.taken = utf8_seq.taken + 2'd1;
        utf8_seq.needed = utf8_seq.needed - 2'd1;
        if (utf8_seq.needed == 2'd0) begin
          cp = utf8_seq.gathered;
          if (cp <= utu_pkg::BmpMax) begin
            if (cp >= utu_pkg::SurrFirst && cp <= utu_pkg::SurrLast) begin
              fresh_units.push_back(utu_pkg::ReplUnit);
            end else begin
              fresh_units.push_back(cp[15:0]);
            end
          end else if (cp <= utu_pkg::MaxPoint) begin
            offset = cp - utu_pkg::PlaneBase;
            fresh_units.push_back(utu_pkg::HighSurr | {6'b000000, offset[19:10]});
            fresh_units.push_back(utu_pkg::LowSurr | {6'b000000, offset[9:0]});
          end else begin
            fresh_units.push_back(utu_pkg::ReplUnit);
          end
          clear_seq();
        end
      end else begin
        fail_seq();
        open_lead(b);
      end
    end else begin
      open_lead(b);
    end
    if (ends_text) begin
      if (utf8_seq.needed != 2'd0) begin
        fail_seq();
      end
      clear_seq();
    end
    for (int i = 0; i < fresh_units.size(); i++) begin
      w.code = fresh_units[i];
      w.run_end = (i == fresh_units.size() - 1);
      w.text_done = ends_text && (i == fresh_units.size() - 1);
      expected_units.push_back(w);
    end
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic ends_text);
    text_item_t it;
    it.value = b;
    it.ends_text = ends_text;
    pending_bytes.push_back(it);
  endtask

  function automatic logic random_end();
    return $urandom_range(0, 99) < end_rate;
  endfunction

  task automatic add_point(input logic [20:0] cp, input int nbytes);
    logic [7:0] lead;
    case (nbytes)
      1: lead = {1'b0, cp[6:0]};
      2: lead = {3'b110, cp[10:6]};
      3: lead = {4'b1110, cp[15:12]};
      default: lead = {5'b11110, cp[20:18]};
    endcase
    add_byte(lead, random_end());
    for (int k = nbytes - 2; k >= 0; k--) begin
      add_byte({2'b10, cp[6*k +: 6]}, random_end());
    end
  endtask

  task automatic add_cut_sequence();
    int         nbytes;
    int         conts;
    logic [7:0] lead;
    nbytes = $urandom_range(2, 4);
    conts = $urandom_range(0, nbytes - 2);
    case (nbytes)
      2: lead = {3'b110, 5'($urandom)};
      3: lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    add_byte(lead, random_end());
    for (int k = 0; k < conts; k++) begin
      add_byte({2'b10, 6'($urandom)}, random_end());
    end
  endtask

  task automatic fill_text();
    int pick;
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_point(21'h0007FF, 2);
    add_point(21'h000000, 2);
    add_point(21'h00D800, 3);
    add_point(21'h00FFFF, 3);
    add_point(21'h010000, 4);
    add_point(21'h1FFFFF, 4);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hC3, 1'b1);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h90, 1'b1);
    end_rate = 4;
    while (pending_bytes.size() < 28 + RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        add_point(21'($urandom_range(0, 16'h007F)), 1);
      end else if (pick < 40) begin
        add_point(21'($urandom_range(0, 16'h07FF)), 2);
      end else if (pick < 55) begin
        if ($urandom_range(0, 3) == 0) begin
          add_point(21'($urandom_range(16'hD800, 16'hDFFF)), 3);
        end else begin
          add_point(21'($urandom_range(0, 16'hFFFF)), 3);
        end
      end else if (pick < 70) begin
        if ($urandom_range(0, 4) == 0) begin
          add_point(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        end else begin
          add_point(21'($urandom_range(0, 21'h10FFFF)), 4);
        end
      end else if (pick < 80) begin
        if ($urandom_range(0, 1) == 0) begin
          add_byte(8'($urandom_range(8'h80, 8'hBF)), random_end());
        end else begin
          add_byte(8'($urandom_range(8'hF8, 8'hFF)), random_end());
        end
      end else if (pick < 92) begin
        add_cut_sequence();
      end else begin
        add_byte(8'($urandom), random_end());
      end
    end
    add_byte(8'h41, 1'b1);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (!text_valid || byte_accepted) begin
      if (pending_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= StallPct)) begin
        next_item = pending_bytes.pop_front();
        text_byte <= next_item.value;
        text_last <= next_item.ends_text;
        text_valid <= 1'b1;
      end else begin
        text_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      unit_stall <= 1'b0;
    end else if (hold_left != 0) begin
      unit_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && cyc >= HoldStart) begin
      unit_stall <= 1'b1;
      hold_left <= HoldCycles - 1;
      hold_done <= 1'b1;
    end else begin
      unit_stall <= !quiet && ($urandom_range(0, 99) < StallPct);
    end
  end

  always @(posedge clk) begin
    byte_accepted <= !rst && text_valid && !text_stall;
    if (!rst) begin
      cyc <= cyc + 1;
      if (unit_valid && !unit_stall) begin
        if (expected_units.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, actual code_unit %h", $time,
                   code_unit);
        end else begin
          want = expected_units.pop_front();
          if (code_unit !== want.code) begin
            mismatches++;
            $display("%0t: code_unit expected %h actual %h", $time, want.code, code_unit);
          end
          if (run_last !== want.run_end) begin
            mismatches++;
            $display("%0t: run_last expected %b actual %b", $time, want.run_end, run_last);
          end
          if (text_end !== want.text_done) begin
            mismatches++;
            $display("%0t: text_end expected %b actual %b", $time, want.text_done,
                     text_end);
          end
        end
      end
      if (text_valid && !text_stall) begin
        predict_utf16(text_byte, text_last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (unit_valid && !unit_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    fill_text();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (pending_bytes.size() == 0 && !text_valid);
    while (expected_units.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
